// File: src/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and constants of the escape decoder
// Character codes, status codes and the result bundle handed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package cesd_pkg;

	localparam int CESD_LINE_COUNT_BITS = 16;
	// queue depth, a power of two
	localparam int CESD_QUEUE_DEPTH     = 4;
	localparam int CESD_COUNT_W         = 16;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [3:0] HEX_TEN      = 4'hA;
	localparam int         VALUE_LIMIT  = 256;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BS_END    = 3'd1,
		ST_HEX_EMPTY = 3'd2,
		ST_HEX_RANGE = 3'd3,
		ST_OCT_RANGE = 3'd4
	} cesd_status_t;

	// everything one input beat produces: up to two data bytes, then status
	typedef struct packed {
		logic                    d0_vld;
		logic [7:0]              d0;
		logic                    d1_vld;
		logic [7:0]              d1;
		logic                    st_vld;
		cesd_status_t            status;
		logic [CESD_COUNT_W-1:0] count;
	} cesd_bundle_t;

endpackage

// File: src/cesd_in_if.sv
// ----------------------------------------------------------------------------
// cesd_in_if: raw byte channel
// Valid/ready channel carrying one escaped byte and its end-of-string mark.
// ----------------------------------------------------------------------------
interface cesd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// File: src/cesd_out_if.sv
// ----------------------------------------------------------------------------
// cesd_out_if: decoded result channel
// Valid/ready channel carrying one decoded byte or one end-of-string status.
// ----------------------------------------------------------------------------
interface cesd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  out_byte;
	logic [2:0]  status;
	logic [15:0] line_total;
	logic        last_result;

	modport source (output valid, output kind, output out_byte, output status,
		output line_total, output last_result, input ready);
	modport sink   (input valid, input kind, input out_byte, input status,
		input line_total, input last_result, output ready);
endinterface

// File: src/cesd_front.sv
// ----------------------------------------------------------------------------
// cesd_front: escape classifier
// Holds the decode mode, escape value, newline counter and error code, and
// turns each accepted byte into at most one result bundle for the queue.
// ----------------------------------------------------------------------------
module cesd_front #(
	parameter int LINE_COUNT_BITS = cesd_pkg::CESD_LINE_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_eos,
	output logic                  push,
	output cesd_pkg::cesd_bundle_t push_data,
	input  logic                  queue_full
);
	import cesd_pkg::*;

	typedef enum logic [2:0] {
		M_PLAIN    = 3'd0,
		M_ESC      = 3'd1,
		M_HEXSTART = 3'd2,
		M_HEX      = 3'd3,
		M_OCT      = 3'd4
	} mode_t;

	mode_t                      mode_q, mode_d;
	logic [8:0]                 val_q, val_d;
	logic [LINE_COUNT_BITS-1:0] nl_q, nl_d;
	cesd_status_t               err_q, err_d, err_fin;

	logic                       hex_ok, oct_ok, digit_ok;
	logic [3:0]                 hex_d;
	logic [12:0]                val_next;
	logic                       nl_hit, plain_go;
	logic                       b0_vld, b1_vld;
	logic [7:0]                 b0, b1;
	logic [CESD_COUNT_W-1:0]    cnt16;
	logic                       accept;

	function automatic logic [7:0] letter_code(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h61:   r = 8'd7;   // a
			8'h62:   r = 8'd8;   // b
			8'h74:   r = 8'd9;   // t
			8'h6E:   r = 8'd10;  // n
			8'h76:   r = 8'd11;  // v
			8'h66:   r = 8'd12;  // f
			8'h72:   r = 8'd13;  // r
			default: r = b;
		endcase
		return r;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = !queue_full;

	// digit decode
	always_comb begin
		hex_ok = 1'b1;
		hex_d  = '0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_d = in_byte[3:0];
		end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
				(in_byte >= 8'h61 && in_byte <= 8'h66)) begin
			hex_d = 4'(in_byte[3:0] - 4'd1 + HEX_TEN);
		end else begin
			hex_ok = 1'b0;
		end
	end
	assign oct_ok   = (in_byte >= 8'h30) && (in_byte <= 8'h37);
	assign digit_ok = (mode_q == M_HEX) ? hex_ok : oct_ok;
	assign val_next = (mode_q == M_HEX) ? ({val_q, 4'h0} + 13'(hex_d))
	                                    : ({1'b0, val_q, 3'h0} + 13'(in_byte[2:0]));

	// next state and results of one byte
	always_comb begin
		mode_d   = mode_q;
		val_d    = val_q;
		err_d    = err_q;
		nl_hit   = 1'b0;
		plain_go = 1'b0;
		b0_vld   = 1'b0;
		b0       = val_q[7:0];
		b1_vld   = 1'b0;
		b1       = in_byte;
		if (err_q == ST_OK) begin
			unique case (mode_q)
				M_ESC: begin
					if (in_byte == CH_X) begin
						mode_d = M_HEXSTART;
					end else if (oct_ok) begin
						val_d  = {6'd0, in_byte[2:0]};
						mode_d = M_OCT;
					end else begin
						nl_hit = (in_byte == CH_NEWLINE);
						b1_vld = 1'b1;
						b1     = letter_code(in_byte);
						mode_d = M_PLAIN;
					end
				end
				M_HEXSTART: begin
					if (hex_ok) begin
						val_d  = {5'd0, hex_d};
						mode_d = M_HEX;
					end else begin
						err_d  = ST_HEX_EMPTY;
						mode_d = M_PLAIN;
					end
				end
				M_HEX, M_OCT: begin
					if (digit_ok) begin
						if (val_next >= 13'(VALUE_LIMIT)) begin
							err_d  = (mode_q == M_HEX) ? ST_HEX_RANGE : ST_OCT_RANGE;
							val_d  = '0;
							mode_d = M_PLAIN;
						end else begin
							val_d = val_next[8:0];
						end
					end else begin
						// digit run ends: emit value, then the byte is plain text
						b0_vld   = 1'b1;
						val_d    = '0;
						mode_d   = M_PLAIN;
						plain_go = 1'b1;
					end
				end
				default: begin
					plain_go = 1'b1;
				end
			endcase
			if (plain_go) begin
				if (in_byte == CH_BACKSLASH) begin
					mode_d = M_ESC;
				end else begin
					nl_hit = (in_byte == CH_NEWLINE);
					b1_vld = 1'b1;
					mode_d = M_PLAIN;
				end
			end
		end
		nl_d = nl_q + LINE_COUNT_BITS'(nl_hit && !(&nl_q));

		// string closes inside an escape
		err_fin = err_d;
		if (in_eos && err_d == ST_OK) begin
			unique case (mode_d)
				M_ESC:        err_fin = ST_BS_END;
				M_HEXSTART:   err_fin = ST_HEX_EMPTY;
				M_HEX, M_OCT: begin
					b0_vld = 1'b1;
					b0     = val_d[7:0];
				end
				default: ;
			endcase
		end
	end

	if (LINE_COUNT_BITS >= CESD_COUNT_W) begin : g_cnt_trunc
		assign cnt16 = nl_d[CESD_COUNT_W-1:0];
	end else begin : g_cnt_ext
		assign cnt16 = {{(CESD_COUNT_W-LINE_COUNT_BITS){1'b0}}, nl_d};
	end

	// bundle for the queue
	always_comb begin
		push_data.d0_vld = b0_vld;
		push_data.d0     = b0;
		push_data.d1_vld = b1_vld;
		push_data.d1     = b1;
		push_data.st_vld = in_eos;
		push_data.status = err_fin;
		push_data.count  = cnt16;
	end
	assign push = accept && (b0_vld || b1_vld || in_eos);

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PLAIN;
			val_q  <= '0;
			nl_q   <= '0;
			err_q  <= ST_OK;
		end else if (accept) begin
			if (in_eos) begin
				mode_q <= M_PLAIN;
				val_q  <= '0;
				nl_q   <= '0;
				err_q  <= ST_OK;
			end else begin
				mode_q <= mode_d;
				val_q  <= val_d;
				nl_q   <= nl_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

// File: src/cesd_queue.sv
// ----------------------------------------------------------------------------
// cesd_queue: bundle queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module cesd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cesd_pkg::cesd_bundle_t push_data,
	output logic                   full,
	input  logic                   pop,
	output logic                   pop_valid,
	output cesd_pkg::cesd_bundle_t pop_data
);
	import cesd_pkg::*;

	localparam int PtrW = $clog2(CESD_QUEUE_DEPTH);
	localparam int CntW = $clog2(CESD_QUEUE_DEPTH + 1);

	cesd_bundle_t    mem_q [CESD_QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full      = (cnt_q == CntW'(CESD_QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
		end
	end

endmodule

// File: src/cesd_back.sv
// ----------------------------------------------------------------------------
// cesd_back: result sequencer
// Takes bundles from the queue and hands out their results one beat at a
// time, data bytes first and the status last.
// ----------------------------------------------------------------------------
module cesd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	output logic                   pop,
	input  logic                   pop_valid,
	input  cesd_pkg::cesd_bundle_t pop_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [7:0]             out_byte,
	output logic [2:0]             status,
	output logic [15:0]            line_total,
	output logic                   last_result
);
	import cesd_pkg::*;

	cesd_bundle_t cur_q;
	logic [2:0]   pend_q;    // pieces still to send: status, data1, data0
	logic [2:0]   pend_rest;
	logic         take, load;

	// pick the first pending piece
	always_comb begin
		kind       = 1'b0;
		out_byte   = cur_q.d1;
		status     = ST_OK;
		line_total = '0;
		pend_rest  = pend_q;
		priority if (pend_q[0]) begin
			out_byte     = cur_q.d0;
			pend_rest[0] = 1'b0;
		end else if (pend_q[1]) begin
			pend_rest[1] = 1'b0;
		end else begin
			kind         = 1'b1;
			out_byte     = '0;
			status       = cur_q.status;
			line_total   = cur_q.count;
			pend_rest[2] = 1'b0;
		end
	end

	assign out_valid   = (pend_q != '0);
	assign last_result = (pend_rest == '0);
	assign take        = out_valid && out_ready;
	assign load        = !out_valid || (take && last_result);
	assign pop         = load && pop_valid;

	// current bundle
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= pop_valid ? {pop_data.st_vld, pop_data.d1_vld, pop_data.d0_vld} : 3'b000;
		end else if (take) begin
			pend_q <= pend_rest;
		end
	end

endmodule

// File: src/c_escape_sequence_decoder.sv
// A byte's bundle is queued when the byte is accepted and then loaded into the back
// end's current-bundle register, from which its results are sent. Throughput: one
// byte per cycle while each byte gives at most one result and the output does not
// stall; the output sends one result per cycle when ready, so a byte giving two or
// three results holds it longer, and a four-entry bundle queue absorbs the burst.
// Reset: arst_n clears the decode mode, escape value, newline count, error and queue.
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: C string escape decoder
// Front end classifies raw bytes and escapes, a queue carries result bundles,
// and the back end sends the decoded bytes and the per-string status.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder #(
	parameter int LINE_COUNT_BITS = cesd_pkg::CESD_LINE_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cesd_in_if.sink   raw,
	cesd_out_if.source decoded
);
	import cesd_pkg::*;

	logic         push, full, pop, pop_valid;
	cesd_bundle_t push_data, pop_data;

	cesd_front #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (raw.valid),
		.in_ready   (raw.ready),
		.in_byte    (raw.in_byte),
		.in_eos     (raw.end_of_string),
		.push       (push),
		.push_data  (push_data),
		.queue_full (full)
	);

	cesd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	cesd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_valid   (pop_valid),
		.pop_data    (pop_data),
		.out_valid   (decoded.valid),
		.out_ready   (decoded.ready),
		.kind        (decoded.kind),
		.out_byte    (decoded.out_byte),
		.status      (decoded.status),
		.line_total  (decoded.line_total),
		.last_result (decoded.last_result)
	);

endmodule

// File: test/cesd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_checker: result checker for the escape decoder
// Watches the raw and decoded channels, decodes every accepted raw beat with
// its own model of the escape rules, and compares each decoded beat with the
// oldest predicted result. Hands the failure count and the number of results
// still due to the testbench top.
// ----------------------------------------------------------------------------
module cesd_checker
	import cesd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cesd_in_if   raw,
	cesd_out_if  decoded,
	output int   fail_count,
	output int   pending_results
);

	typedef enum logic [2:0] {
		M_PLAIN,
		M_ESC,
		M_HEX_START,
		M_HEX,
		M_OCT
	} dec_mode_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [15:0] lines;
		logic        last;
	} dec_result_t;

	// decoder state as seen from the outside
	dec_mode_t                       mode;
	logic [8:0]                      esc_val;
	logic [CESD_LINE_COUNT_BITS-1:0] line_cnt;
	cesd_status_t                    err;

	dec_result_t due_q[$];
	dec_result_t got, want;
	int          fails;

	function automatic int hex_val(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "A" && b <= "F") return b - "A" + HEX_TEN;
		if (b >= "a" && b <= "f") return b - "a" + HEX_TEN;
		return -1;
	endfunction

	function automatic int oct_digit(logic [7:0] b);
		if (b >= "0" && b <= "7") return b - "0";
		return -1;
	endfunction

	function automatic logic [7:0] letter_byte(logic [7:0] b);
		case (b)
			"a": return 8'd7;
			"b": return 8'd8;
			"t": return 8'd9;
			"n": return 8'd10;
			"v": return 8'd11;
			"f": return 8'd12;
			"r": return 8'd13;
			default: return b;
		endcase
	endfunction

	function automatic dec_result_t data_result(logic [7:0] b);
		dec_result_t r;
		r      = '0;
		r.data = b;
		return r;
	endfunction

	task automatic clear_state();
		mode     = M_PLAIN;
		esc_val  = '0;
		line_cnt = '0;
		err      = ST_OK;
	endtask

	// raw newline count, saturating
	task automatic count_line(logic [7:0] b);
		if (b == CH_NEWLINE && line_cnt != '1)
			line_cnt++;
	endtask

	// decode one raw beat, queue the results it causes
	task automatic decode_byte(logic [7:0] b, logic eos);
		dec_result_t outs[$];
		dec_result_t st;
		int          d;
		int          acc;
		logic        as_plain;
		as_plain = 1'b0;
		if (err == ST_OK) begin
			case (mode)
				M_ESC: begin
					if (b == CH_X) begin
						mode = M_HEX_START;
					end else if (oct_digit(b) >= 0) begin
						esc_val = 9'(oct_digit(b));
						mode    = M_OCT;
					end else begin
						count_line(b);
						outs.push_back(data_result(letter_byte(b)));
						mode = M_PLAIN;
					end
				end
				M_HEX_START: begin
					d = hex_val(b);
					if (d >= 0) begin
						esc_val = 9'(d);
						mode    = M_HEX;
					end else begin
						err  = ST_HEX_EMPTY;
						mode = M_PLAIN;
					end
				end
				M_HEX, M_OCT: begin
					d = (mode == M_HEX) ? hex_val(b) : oct_digit(b);
					if (d >= 0) begin
						acc = int'(esc_val) * ((mode == M_HEX) ? 16 : 8) + d;
						if (acc >= VALUE_LIMIT) begin
							err     = (mode == M_HEX) ? ST_HEX_RANGE : ST_OCT_RANGE;
							esc_val = '0;
							mode    = M_PLAIN;
						end else begin
							esc_val = 9'(acc);
						end
					end else begin
						// digit run ends, the byte goes on as plain text
						outs.push_back(data_result(esc_val[7:0]));
						esc_val  = '0;
						mode     = M_PLAIN;
						as_plain = 1'b1;
					end
				end
				default: as_plain = 1'b1;
			endcase
			if (as_plain) begin
				if (b == CH_BACKSLASH) begin
					mode = M_ESC;
				end else begin
					count_line(b);
					outs.push_back(data_result(b));
				end
			end
		end

		// end of string: close any open escape, then the status beat
		if (eos) begin
			if (err == ST_OK) begin
				case (mode)
					M_ESC:        err = ST_BS_END;
					M_HEX_START:  err = ST_HEX_EMPTY;
					M_HEX, M_OCT: outs.push_back(data_result(esc_val[7:0]));
					default:      ;
				endcase
			end
			st        = '0;
			st.kind   = 1'b1;
			st.status = err;
			st.lines  = line_cnt[15:0];
			outs.push_back(st);
			clear_state();
		end

		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			due_q.push_back(outs[i]);
	endtask

	// predict on raw beats, compare on decoded beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			due_q.delete();
			fails = 0;
			fail_count      <= 0;
			pending_results <= 0;
		end else begin
			if (raw.valid && raw.ready)
				decode_byte(raw.in_byte, raw.end_of_string);
			if (decoded.valid && decoded.ready) begin
				got = {decoded.kind, decoded.out_byte, decoded.status,
					decoded.line_total, decoded.last_result};
				if (due_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected beat, expected none,", $time,
						" actual kind=%0d byte=%02h", got.kind, got.data,
						" status=%0d lines=%0d last=%0d", got.status, got.lines, got.last);
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: mismatch, expected kind=%0d byte=%02h", $time,
							want.kind, want.data,
							" status=%0d lines=%0d last=%0d",
							want.status, want.lines, want.last);
						$display("%0t:           actual kind=%0d byte=%02h", $time,
							got.kind, got.data,
							" status=%0d lines=%0d last=%0d",
							got.status, got.lines, got.last);
					end
				end
			end
			fail_count      <= fails;
			pending_results <= due_q.size();
		end
	end

endmodule

// File: test/tb_c_escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_escape_sequence_decoder: testbench of the escape decoder
// Sends directed escaped strings, then random strings of plain bytes and valid
// escapes with some broken ones, under three idling mixes on the two channels.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_c_escape_sequence_decoder;
	import cesd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_BYTES = 120;
	localparam int DRAIN_WAIT  = 10;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_results;
	int   src_idle;
	int   snk_idle;
	int   sent;
	int   cycles;
	bit   paused;
	logic [7:0] str_q[$];

	cesd_in_if  raw_ch();
	cesd_out_if dec_ch();

	c_escape_sequence_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.decoded (dec_ch)
	);

	cesd_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.raw             (raw_ch),
		.decoded         (dec_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at the current rate
	initial begin
		dec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			dec_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// one raw beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < src_idle) begin
			raw_ch.valid <= 1'b0;
			@(posedge clk);
		end
		raw_ch.valid         <= 1'b1;
		raw_ch.in_byte       <= b;
		raw_ch.end_of_string <= eos;
		do @(posedge clk); while (!raw_ch.ready);
	endtask

	task automatic send_queued();
		foreach (str_q[i])
			send_beat(str_q[i], i == str_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		str_q.delete();
		for (int i = 0; i < s.len(); i++)
			str_q.push_back(s[i]);
		send_queued();
	endtask

	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	function automatic logic [7:0] hex_char(int v);
		if (v < 10) return 8'("0" + v);
		return $urandom_range(1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	// one random piece of escaped text
	task automatic add_token();
		int         pick;
		int         nd;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 28) begin
			b = 8'($urandom_range(255));
			if (b == CH_BACKSLASH) b = "z";
			str_q.push_back(b);
		end else if (pick < 36) begin
			str_q.push_back(CH_NEWLINE);
		end else if (pick < 50) begin
			// letter and pass-through escapes
			str_q.push_back(CH_BACKSLASH);
			case ($urandom_range(11))
				0: b = "a";
				1: b = "b";
				2: b = "t";
				3: b = "n";
				4: b = "v";
				5: b = "f";
				6: b = "r";
				7: b = CH_BACKSLASH;
				8: b = CH_NEWLINE;
				9: b = "\"";
				default: begin
					b = 8'($urandom_range(255));
					if (b == CH_X || (b >= "0" && b <= "7")) b = "?";
				end
			endcase
			str_q.push_back(b);
		end else if (pick < 64) begin
			// hex in range, sometimes with leading zeros
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_X);
			nd = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (nd) str_q.push_back("0");
			nd = $urandom_range(1, 2);
			repeat (nd) str_q.push_back(hex_char($urandom_range(15)));
		end else if (pick < 78) begin
			// octal in range
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(8'("0" + $urandom_range(3)));
			nd = $urandom_range(2);
			repeat (nd) str_q.push_back(8'("0" + $urandom_range(7)));
		end else if (pick < 86) begin
			// value of 256 or more
			str_q.push_back(CH_BACKSLASH);
			if ($urandom_range(1)) begin
				str_q.push_back(CH_X);
				str_q.push_back(hex_char($urandom_range(1, 15)));
				repeat (2) str_q.push_back(hex_char($urandom_range(15)));
			end else begin
				str_q.push_back(8'("4" + $urandom_range(3)));
				repeat (2) str_q.push_back(8'("0" + $urandom_range(7)));
			end
		end else if (pick < 91) begin
			// backslash-x with no digit after it
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_X);
			str_q.push_back(8'("g" + $urandom_range(19)));
		end else begin
			str_q.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic build_string();
		int ntok;
		int tail;
		str_q.delete();
		ntok = $urandom_range(1, 8);
		repeat (ntok) add_token();
		// now and then the string ends inside an escape
		tail = $urandom_range(19);
		if (tail == 0) begin
			str_q.push_back(CH_BACKSLASH);
		end else if (tail == 1) begin
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_X);
		end
	endtask

	initial begin
		raw_ch.valid         <= 1'b0;
		raw_ch.in_byte       <= '0;
		raw_ch.end_of_string <= 1'b0;
		arst_n               <= 1'b0;
		src_idle = 36;
		snk_idle = 77;
		paused   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		str_q = {8'h00, 8'hFF, CH_NEWLINE};
		send_queued();
		send_text("\\a\\r\\\n\\q");
		send_text("\\x41Z\\1018");
		send_text("\\xfF");
		send_text("\\400\n");
		send_text("\\x100");
		send_text("\\xg");
		send_text("\\");
		send_text("\\x");
		send_text("\\7");
		wait_drained();

		// random strings under three idling mixes
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 36 : (ph == 1) ? 77 : 0;
			snk_idle = (ph == 0) ? 77 : (ph == 1) ? 36 : 0;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_string();
				sent += str_q.size();
				send_queued();
				// hold off once until the output has caught up
				if (!paused && sent >= PHASE_BYTES / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
